FILE: hw/rtl/kt_binned_pair_histogrammer_defines.svh
// Assertion macros shared by the histogrammer RTL.
`ifndef KT_BINNED_PAIR_HISTOGRAMMER_DEFINES_SVH
`define KT_BINNED_PAIR_HISTOGRAMMER_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define KBPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define KBPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/kbph_pkg.sv
// Types, codes and constants of the binned pair histogrammer.
package kbph_pkg;

  localparam int MAX_KT_BINS_DEF = 16;
  localparam int MAX_Q_BINS_DEF  = 64;

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 32;

  // shared divider: 16-bit operands, one quotient bit per cycle
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // operation codes; every other code is a read
  localparam logic [1:0] OP_ADD_REAL  = 2'd0;
  localparam logic [1:0] OP_ADD_MIXED = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KT_W    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KT_BINS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_BINS  = 3'd5;

  localparam logic [15:0] KT_LOW_RST  = 16'd0;
  localparam logic [15:0] KT_W_RST    = 16'd100;
  localparam logic [4:0]  KT_BINS_RST = 5'd16;
  localparam logic [15:0] Q_LOW_RST   = 16'd0;
  localparam logic [15:0] Q_W_RST     = 16'd10;
  localparam logic [6:0]  Q_BINS_RST  = 7'd64;

  typedef enum logic [1:0] {
    ST_FILLED   = 2'd0,
    ST_CUT      = 2'd1,
    ST_KT_RANGE = 2'd2,
    ST_READ     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV_KT,
    S_DIV_Q,
    S_RMW_RD,
    S_RMW_WR,
    S_READ,
    S_READ_CAP,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    load_item;
    logic    div_start;
    logic    div_sel_q;
    logic    kidx_load;
    logic    qbin_load;
    logic    qbin_zero;
    logic    ram_rd;
    logic    ram_wr;
    logic    clr_wr;
    logic    cnt_from_inc;
    logic    cnt_from_rd;
    logic    res_load;
    status_e res_status;
  } kbph_cmd_t;

  typedef struct packed {
    logic is_read;
    logic cut_fail;
    logic kt_below;
    logic kt_in_range;
    logic q_below;
    logic div_busy;
    logic clr_last;
    logic out_free;
  } kbph_sts_t;

endpackage

FILE: hw/rtl/kbph_ram.sv
// Generic single-port RAM with registered read.
module kbph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1056
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/kbph_ctrl.sv
// Sequencer of the histogrammer: clear sweep, binning steps, result hand-off.
module kbph_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  kbph_pkg::kbph_sts_t sts_i,
  output kbph_pkg::kbph_cmd_t cmd_o
);
  import kbph_pkg::*;

  ctrl_state_e state_q, state_d;
  status_e     res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      res_q   <= ST_FILLED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.is_read) begin
          res_d   = ST_READ;
          state_d = S_READ;
        end else if (sts_i.cut_fail) begin
          res_d   = ST_CUT;
          state_d = S_DONE;
        end else if (sts_i.kt_below) begin
          res_d   = ST_KT_RANGE;
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV_KT;
        end
      end
      S_DIV_KT: begin
        if (!sts_i.div_busy) begin
          priority if (!sts_i.kt_in_range) begin
            res_d   = ST_KT_RANGE;
            state_d = S_DONE;
          end else if (sts_i.q_below) begin
            cmd_o.kidx_load = 1'b1;
            cmd_o.qbin_load = 1'b1;
            cmd_o.qbin_zero = 1'b1;
            state_d         = S_RMW_RD;
          end else begin
            cmd_o.kidx_load = 1'b1;
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel_q = 1'b1;
            state_d         = S_DIV_Q;
          end
        end
      end
      S_DIV_Q: begin
        if (!sts_i.div_busy) begin
          cmd_o.qbin_load = 1'b1;
          state_d         = S_RMW_RD;
        end
      end
      S_RMW_RD: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd_o.ram_wr       = 1'b1;
        cmd_o.cnt_from_inc = 1'b1;
        res_d              = ST_FILLED;
        state_d            = S_DONE;
      end
      S_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_READ_CAP;
      end
      S_READ_CAP: begin
        cmd_o.cnt_from_rd = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        cmd_o.res_status = res_q;
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: hw/rtl/kbph_dp.sv
// Datapath: config registers, item latch, serial divider, count stores, result register.
module kbph_dp #(
  parameter int MAX_KT_BINS = kbph_pkg::MAX_KT_BINS_DEF,
  parameter int MAX_Q_BINS  = kbph_pkg::MAX_Q_BINS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kbph_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [kbph_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [1:0]                         op_i,
  input  logic [15:0]                        kt_i,
  input  logic [15:0]                        q_i,
  input  logic                               pass_i,
  input  logic                               rden_i,
  input  logic [3:0]                         rkt_i,
  input  logic [6:0]                         rq_i,
  input  kbph_pkg::kbph_cmd_t                cmd_i,
  output kbph_pkg::kbph_sts_t                sts_o,
  input  logic                               m_ready_i,
  output logic                               m_valid_o,
  output logic [1:0]                         status_o,
  output logic [3:0]                         fkt_o,
  output logic [6:0]                         fq_o,
  output logic [kbph_pkg::COUNT_W-1:0]       count_o
);
  import kbph_pkg::*;

  localparam int ROW_LEN = MAX_Q_BINS + 2;
  localparam int DEPTH   = MAX_KT_BINS * ROW_LEN;
  localparam int AW      = $clog2(DEPTH);
  localparam int KBW     = (MAX_KT_BINS > 1) ? $clog2(MAX_KT_BINS) : 1;
  localparam int QBW     = $clog2(ROW_LEN);

  // configuration
  logic [15:0] kt_low_q, kt_w_q, q_low_q, q_w_q;
  logic [4:0]  kt_bins_q;
  logic [6:0]  q_bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kt_low_q  <= KT_LOW_RST;
      kt_w_q    <= KT_W_RST;
      kt_bins_q <= KT_BINS_RST;
      q_low_q   <= Q_LOW_RST;
      q_w_q     <= Q_W_RST;
      q_bins_q  <= Q_BINS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_KT_LOW:  kt_low_q  <= cfg_wdata_i;
        CFG_KT_W:    kt_w_q    <= cfg_wdata_i;
        CFG_KT_BINS: kt_bins_q <= cfg_wdata_i[4:0];
        CFG_Q_LOW:   q_low_q   <= cfg_wdata_i;
        CFG_Q_W:     q_w_q     <= cfg_wdata_i;
        CFG_Q_BINS:  q_bins_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // latched item
  logic [1:0]  op_q;
  logic [15:0] kt_q, q_q;
  logic        pass_q, rden_q;
  logic [3:0]  rkt_q;
  logic [6:0]  rq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= op_i;
      kt_q   <= kt_i;
      q_q    <= q_i;
      pass_q <= pass_i;
      rden_q <= rden_i;
      rkt_q  <= rkt_i;
      rq_q   <= rq_i;
    end
  end

  logic        is_read, sel_den, rd_in_range;
  logic [15:0] q_abs, nkt, nq, kt_w_nz, q_w_nz;

  assign is_read = !(op_q == OP_ADD_REAL || op_q == OP_ADD_MIXED);
  assign sel_den = is_read ? rden_q : (op_q == OP_ADD_MIXED);
  // 0x8000 maps onto itself, which is its magnitude as unsigned
  assign q_abs   = q_q[15] ? (~q_q + 16'd1) : q_q;
  assign kt_w_nz = (kt_w_q == 16'd0) ? 16'd1 : kt_w_q;
  assign q_w_nz  = (q_w_q == 16'd0) ? 16'd1 : q_w_q;
  assign nkt = ({11'd0, kt_bins_q} > 16'(MAX_KT_BINS)) ? 16'(MAX_KT_BINS)
                                                        : {11'd0, kt_bins_q};
  assign nq  = ({9'd0, q_bins_q} > 16'(MAX_Q_BINS)) ? 16'(MAX_Q_BINS)
                                                     : {9'd0, q_bins_q};
  assign rd_in_range = (32'(rkt_q) < 32'(MAX_KT_BINS)) && (32'(rq_q) < 32'(ROW_LEN));

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]     quo_q, rem_q, dvs_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_W:0]       rem_sh, rem_sub;
  logic                 div_busy;

  assign div_busy = (div_cnt_q != '0);
  assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DIV_CNT_W'(DIV_W);
    end else if (div_busy) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q <= cmd_i.div_sel_q ? (q_abs - q_low_q) : (kt_q - kt_low_q);
      dvs_q <= cmd_i.div_sel_q ? q_w_nz : kt_w_nz;
      rem_q <= '0;
    end else if (div_busy) begin
      if (!rem_sub[DIV_W]) begin
        rem_q <= rem_sub[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // bin indexes
  logic [KBW-1:0] kidx_q;
  logic [QBW-1:0] qbin_q;
  logic [15:0]    qbin_div;

  assign qbin_div = (quo_q < nq) ? (quo_q + 16'd1) : (nq + 16'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.kidx_load) begin
      kidx_q <= quo_q[KBW-1:0];
    end
    if (cmd_i.qbin_load) begin
      qbin_q <= cmd_i.qbin_zero ? '0 : qbin_div[QBW-1:0];
    end
  end

  // count stores
  logic [AW-1:0]      clr_addr_q, ram_addr, fill_addr, rd_addr;
  logic               clr_last, num_we, den_we, ram_re;
  logic [COUNT_W-1:0] ram_wdata, num_rdata, den_rdata, rd_word, inc_word;

  assign clr_last  = (clr_addr_q == AW'(DEPTH - 1));
  assign fill_addr = AW'(32'(kidx_q) * 32'(ROW_LEN) + 32'(qbin_q));
  assign rd_addr   = AW'(32'(rkt_q) * 32'(ROW_LEN) + 32'(rq_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_wr && !clr_last) begin
      clr_addr_q <= clr_addr_q + AW'(1);
    end
  end

  always_comb begin
    if (cmd_i.clr_wr) begin
      ram_addr  = clr_addr_q;
      ram_wdata = '0;
      num_we    = 1'b1;
      den_we    = 1'b1;
    end else begin
      ram_addr  = is_read ? rd_addr : fill_addr;
      ram_wdata = inc_word;
      num_we    = cmd_i.ram_wr && !sel_den;
      den_we    = cmd_i.ram_wr && sel_den;
    end
  end

  assign ram_re   = cmd_i.ram_rd && (!is_read || rd_in_range);
  assign rd_word  = sel_den ? den_rdata : num_rdata;
  assign inc_word = (rd_word == '1) ? rd_word : (rd_word + COUNT_W'(1));

  kbph_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (num_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (num_rdata)
  );

  kbph_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (DEPTH)
  ) u_den_ram (
    .clk_i   (clk_i),
    .we_i    (den_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (den_rdata)
  );

  logic [COUNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_from_inc) begin
      cnt_q <= inc_word;
    end else if (cmd_i.cnt_from_rd) begin
      cnt_q <= rd_in_range ? rd_word : '0;
    end
  end

  // result register
  logic               m_valid_q;
  status_e            out_status_q;
  logic [3:0]         out_fkt_q;
  logic [6:0]         out_fq_q;
  logic [COUNT_W-1:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_status_q <= cmd_i.res_status;
      out_fkt_q    <= (cmd_i.res_status == ST_FILLED) ? 4'(kidx_q) : 4'd0;
      out_fq_q     <= (cmd_i.res_status == ST_FILLED) ? 7'(qbin_q) : 7'd0;
      out_cnt_q    <= (cmd_i.res_status == ST_FILLED || cmd_i.res_status == ST_READ)
                      ? cnt_q : '0;
    end
  end

  assign m_valid_o = m_valid_q;
  assign status_o  = out_status_q;
  assign fkt_o     = out_fkt_q;
  assign fq_o      = out_fq_q;
  assign count_o   = out_cnt_q;

  assign sts_o.is_read     = is_read;
  assign sts_o.cut_fail    = !pass_q;
  assign sts_o.kt_below    = (kt_q < kt_low_q);
  assign sts_o.kt_in_range = (quo_q < nkt);
  assign sts_o.q_below     = (q_abs < q_low_q);
  assign sts_o.div_busy    = div_busy;
  assign sts_o.clr_last    = clr_last;
  assign sts_o.out_free    = !m_valid_q || m_ready_i;

endmodule

FILE: hw/rtl/kt_binned_pair_histogrammer.sv
// Top level of the kT-binned pair histogrammer.
//
//   port group    dir  contents
//   s_axis        in   pair fill or count read item
//   m_axis        out  one result item per input item
//   cfg           in   bin edge, width and count registers, write only
//
// A pair that fails the cut or lies below the kT low edge goes straight to the result;
// a read reads the count store; a fill runs the 16-step shared divider for kT and, unless
// qinv is below its low edge, for qinv, then a read-modify-write on one count store port.
// After reset the block sweeps all MAX_KT_BINS*(MAX_Q_BINS+2) entries (1056 at the
// defaults) of both count stores to zero, with s_axis_tready_o low.
// A finished result waits in the output register while the next item is taken.
`include "kt_binned_pair_histogrammer_defines.svh"

module kt_binned_pair_histogrammer #(
  parameter int MAX_KT_BINS = kbph_pkg::MAX_KT_BINS_DEF,
  parameter int MAX_Q_BINS  = kbph_pkg::MAX_Q_BINS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // kt_value[15:0], q_value[31:16], cut_pass[32], read_denominator[33],
  // read_kt_bin[37:34], read_q_bin[44:38], zero fill above
  input  logic [kbph_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // operation[1:0]
  input  logic [kbph_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // filled_kt_bin[3:0], filled_q_bin[10:4], count_value[42:11], zero fill above
  output logic [kbph_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status[1:0]
  output logic [kbph_pkg::OUT_TUSER_W-1:0]   m_axis_tuser_o,
  input  logic                               cfg_we_i,
  input  logic [kbph_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [kbph_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import kbph_pkg::*;

  kbph_cmd_t          cmd;
  kbph_sts_t          sts;
  logic [1:0]         status;
  logic [3:0]         fkt;
  logic [6:0]         fq;
  logic [COUNT_W-1:0] count;

  kbph_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  kbph_dp #(
    .MAX_KT_BINS (MAX_KT_BINS),
    .MAX_Q_BINS  (MAX_Q_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser_i[1:0]),
    .kt_i        (s_axis_tdata_i[15:0]),
    .q_i         (s_axis_tdata_i[31:16]),
    .pass_i      (s_axis_tdata_i[32]),
    .rden_i      (s_axis_tdata_i[33]),
    .rkt_i       (s_axis_tdata_i[37:34]),
    .rq_i        (s_axis_tdata_i[44:38]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .status_o    (status),
    .fkt_o       (fkt),
    .fq_o        (fq),
    .count_o     (count)
  );

  assign m_axis_tdata_o = {5'd0, count, fq, fkt};
  assign m_axis_tuser_o = status;

  `KBPH_ASSERT_IMP(a_res_slot_free, cmd.res_load, sts.out_free, "result loaded over a pending item")
  `KBPH_ASSERT_NXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "second item taken while busy")
  `KBPH_ASSERT_IMP(a_no_take_in_clear, cmd.clr_wr, !s_axis_tready_o, "item taken during clear sweep")
  `KBPH_ASSERT_IMP(a_div_idle_start, cmd.div_start, !sts.div_busy, "divider restarted while busy")
  `KBPH_ASSERT_IMP(a_rmw_order, cmd.ram_wr, $past(cmd.ram_rd), "count written without prior read")

endmodule

FILE: tb/kt_binned_pair_histogrammer_checker.sv
// Checker for the binned pair histogrammer: bins each accepted item and compares every result.
module kt_binned_pair_histogrammer_checker #(
  parameter int MAX_KT_BINS = kbph_pkg::MAX_KT_BINS_DEF,
  parameter int MAX_Q_BINS  = kbph_pkg::MAX_Q_BINS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // kt_value[15:0], q_value[31:16], cut_pass[32], read_denominator[33],
  // read_kt_bin[37:34], read_q_bin[44:38]
  input  logic [kbph_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // operation[1:0]
  input  logic [kbph_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  // filled_kt_bin[3:0], filled_q_bin[10:4], count_value[42:11]
  input  logic [kbph_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  // status[1:0]
  input  logic [kbph_pkg::OUT_TUSER_W-1:0] m_axis_tuser_i,
  input  logic                             cfg_we_i,
  input  logic [kbph_pkg::CFG_IDX_W-1:0]   cfg_addr_i,
  input  logic [kbph_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                               mismatches_o,
  output int                               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import kbph_pkg::*;

  localparam int ROW_LEN = MAX_Q_BINS + 2;

  typedef struct {
    status_e            status;
    logic [3:0]         kt_bin;
    logic [6:0]         q_bin;
    logic [COUNT_W-1:0] count;
  } bin_result_t;

  logic [15:0] kt_low_edge, kt_bin_width, q_low_edge, q_bin_width;
  logic [4:0]  kt_bins_used;
  logic [6:0]  q_bins_used;

  logic [COUNT_W-1:0] real_counts  [MAX_KT_BINS][ROW_LEN];
  logic [COUNT_W-1:0] mixed_counts [MAX_KT_BINS][ROW_LEN];

  bin_result_t expected_bins [$];
  int          mismatches = 0;

  assign mismatches_o = mismatches;

  // Bins one item, updates the count stores and returns the result it must produce.
  function automatic bin_result_t bin_and_count(input logic [1:0] op, input logic [15:0] kt,
      input logic [15:0] q, input logic pass, input logic rden, input logic [3:0] rkt,
      input logic [6:0] rq);
    bin_result_t r;
    int unsigned nkt, nq, kidx, mag, qbin, kw, qw;
    r.status = ST_READ;
    r.kt_bin = '0;
    r.q_bin  = '0;
    r.count  = '0;
    if (op != OP_ADD_REAL && op != OP_ADD_MIXED) begin
      if (int'(rkt) < MAX_KT_BINS && int'(rq) < ROW_LEN)
        r.count = rden ? mixed_counts[rkt][rq] : real_counts[rkt][rq];
    end else if (!pass) begin
      r.status = ST_CUT;
    end else if (kt < kt_low_edge) begin
      // below the first edge is out of range, not bin 0
      r.status = ST_KT_RANGE;
    end else begin
      nkt  = (32'(kt_bins_used) > MAX_KT_BINS) ? MAX_KT_BINS : 32'(kt_bins_used);
      kw   = (kt_bin_width == 0) ? 1 : 32'(kt_bin_width);
      kidx = (32'(kt) - 32'(kt_low_edge)) / kw;
      if (kidx >= nkt) begin
        r.status = ST_KT_RANGE;
      end else begin
        nq  = (32'(q_bins_used) > MAX_Q_BINS) ? MAX_Q_BINS : 32'(q_bins_used);
        qw  = (q_bin_width == 0) ? 1 : 32'(q_bin_width);
        mag = q[15] ? 32'h1_0000 - 32'(q) : 32'(q);
        if (mag < 32'(q_low_edge))
          qbin = 0;
        else begin
          qbin = (mag - 32'(q_low_edge)) / qw;
          qbin = (qbin < nq) ? qbin + 1 : nq + 1;
        end
        if (op == OP_ADD_REAL) begin
          if (real_counts[kidx][qbin] != '1) real_counts[kidx][qbin]++;
          r.count = real_counts[kidx][qbin];
        end else begin
          if (mixed_counts[kidx][qbin] != '1) mixed_counts[kidx][qbin]++;
          r.count = mixed_counts[kidx][qbin];
        end
        r.status = ST_FILLED;
        r.kt_bin = kidx[3:0];
        r.q_bin  = qbin[6:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    bin_result_t want;
    if (!rst_ni) begin
      kt_low_edge  = KT_LOW_RST;
      kt_bin_width = KT_W_RST;
      kt_bins_used = KT_BINS_RST;
      q_low_edge   = Q_LOW_RST;
      q_bin_width  = Q_W_RST;
      q_bins_used  = Q_BINS_RST;
      foreach (real_counts[i, j]) begin
        real_counts[i][j]  = '0;
        mixed_counts[i][j] = '0;
      end
      expected_bins.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_KT_LOW:  kt_low_edge  = cfg_wdata_i;
          CFG_KT_W:    kt_bin_width = cfg_wdata_i;
          CFG_KT_BINS: kt_bins_used = cfg_wdata_i[4:0];
          CFG_Q_LOW:   q_low_edge   = cfg_wdata_i;
          CFG_Q_W:     q_bin_width  = cfg_wdata_i;
          CFG_Q_BINS:  q_bins_used  = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      // result first: it can only belong to an item taken at an earlier edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_bins.size() == 0) begin
          $error("result item with no item pending");
          mismatches++;
        end else begin
          want = expected_bins.pop_front();
          if (m_axis_tuser_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_i);
            mismatches++;
          end
          if (m_axis_tdata_i[3:0] !== want.kt_bin) begin
            $error("filled_kt_bin: expected %0d, got %0d", want.kt_bin, m_axis_tdata_i[3:0]);
            mismatches++;
          end
          if (m_axis_tdata_i[10:4] !== want.q_bin) begin
            $error("filled_q_bin: expected %0d, got %0d", want.q_bin, m_axis_tdata_i[10:4]);
            mismatches++;
          end
          if (m_axis_tdata_i[42:11] !== want.count) begin
            $error("count_value: expected %0d, got %0d", want.count, m_axis_tdata_i[42:11]);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        want = bin_and_count(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[31:16],
            s_axis_tdata_i[32], s_axis_tdata_i[33], s_axis_tdata_i[37:34],
            s_axis_tdata_i[44:38]);
        expected_bins.insert(expected_bins.size(), want);
      end
    end
    outstanding_o <= expected_bins.size();
  end

endmodule

FILE: tb/tb_kt_binned_pair_histogrammer.sv
// Testbench top for the binned pair histogrammer: clock, reset, stimulus and verdict.
module tb_kt_binned_pair_histogrammer;
  timeunit 1ns;
  timeprecision 1ps;
  import kbph_pkg::*;

  localparam logic [1:0] OP_READ     = 2'd2;
  localparam logic [1:0] OP_READ_ALT = 2'd3;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 325;
  localparam int PHASES          = 6;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] kt;
    logic [15:0] q;
    logic        pass;
    logic        rden;
    logic [3:0]  rkt;
    logic [6:0]  rq;
  } pair_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int send_idle_pct = 24;
  int recv_idle_pct = 52;
  int holdoff_len = 0;

  // current binning, used only to aim the random items
  logic [15:0] cur_kt_low = KT_LOW_RST, cur_kt_w = KT_W_RST;
  logic [15:0] cur_q_low = Q_LOW_RST, cur_q_w = Q_W_RST;
  logic [4:0]  cur_kt_bins = KT_BINS_RST;
  logic [6:0]  cur_q_bins = Q_BINS_RST;

  kt_binned_pair_histogrammer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  kt_binned_pair_histogrammer_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** kt_binned_pair_histogrammer: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit holdoff_taken;
    holdoff_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_len != 0 && !holdoff_taken) begin
        holdoff_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (holdoff_len) @(posedge clk_i);
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_pair(input logic [1:0] op, input logic [15:0] kt, input logic [15:0] q,
      input logic pass, input logic rden, input logic [3:0] rkt, input logic [6:0] rq);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {3'b000, rq, rkt, rden, pass, q, kt};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // stop offering items until every result is back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_binning(input logic [15:0] kt_low, input logic [15:0] kt_w,
      input logic [4:0] kt_bins, input logic [15:0] q_low, input logic [15:0] q_w,
      input logic [6:0] q_bins);
    logic [CFG_IDX_W-1:0]  idx  [6];
    logic [CFG_DATA_W-1:0] vals [6];
    idx  = '{CFG_KT_LOW, CFG_KT_W, CFG_KT_BINS, CFG_Q_LOW, CFG_Q_W, CFG_Q_BINS};
    vals = '{kt_low, kt_w, 16'(kt_bins), q_low, q_w, 16'(q_bins)};
    cur_kt_low  = kt_low;
    cur_kt_w    = kt_w;
    cur_kt_bins = kt_bins;
    cur_q_low   = q_low;
    cur_q_w     = q_w;
    cur_q_bins  = q_bins;
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly in-range pairs that pass the cut, aimed at the configured bins
  function automatic pair_item_t random_pair();
    pair_item_t p;
    int unsigned pick, width, span, v, nq;
    pick = $urandom_range(0, 99);
    if (pick < 40)      p.op = OP_ADD_REAL;
    else if (pick < 75) p.op = OP_ADD_MIXED;
    else if (pick < 88) p.op = OP_READ;
    else                p.op = OP_READ_ALT;
    p.pass = ($urandom_range(0, 99) < 90);

    width = (cur_kt_w == 0) ? 1 : 32'(cur_kt_w);
    span  = width * ((cur_kt_bins > MAX_KT_BINS_DEF) ? MAX_KT_BINS_DEF : 32'(cur_kt_bins))
            + width;
    pick  = $urandom_range(0, 99);
    if (pick < 80) begin
      v = 32'(cur_kt_low) + $urandom_range(0, span);
      if (v > 65535) v = 65535;
      p.kt = v[15:0];
    end else if (pick < 90 && cur_kt_low != 0) begin
      p.kt = 16'($urandom_range(0, 32'(cur_kt_low) - 1));
    end else begin
      p.kt = 16'($urandom);
    end

    width = (cur_q_w == 0) ? 1 : 32'(cur_q_w);
    nq    = (cur_q_bins > MAX_Q_BINS_DEF) ? MAX_Q_BINS_DEF : 32'(cur_q_bins);
    if ($urandom_range(0, 99) < 80) begin
      v = 32'(cur_q_low) + $urandom_range(0, width * nq + width);
      if (v > 32767) v = 32767;
      p.q = $urandom_range(0, 1) ? -v[15:0] : v[15:0];
    end else begin
      p.q = 16'($urandom);
    end

    p.rden = 1'($urandom_range(0, 1));
    p.rkt  = 4'($urandom_range(0, 15));
    p.rq   = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, nq + 1))
                                          : 7'($urandom_range(0, 127));
    return p;
  endfunction

  initial begin : stimulus
    pair_item_t p;
    int random_sent;
    random_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset binning: kT bins of 100, qinv bins of 10, 16 x 64
    push_pair(OP_ADD_REAL,  16'd0,     16'd0,     1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd0,     16'd0,     1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_MIXED, 16'd65535, 16'hFFFF,  1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd1599,  16'h8000,  1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd1500,  16'h7FFF,  1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_MIXED, 16'd50,    -16'd5,    1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd0,     16'd639,   1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd0,     16'd640,   1'b1, 1'b0, 4'd0,  7'd0);
    // cut failure wins over an out-of-range kT
    push_pair(OP_ADD_REAL,  16'd65535, 16'd3,     1'b0, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_MIXED, 16'd10,    16'd3,     1'b0, 1'b0, 4'd0,  7'd0);
    push_pair(OP_READ,      16'd0,     16'd0,     1'b0, 1'b0, 4'd0,  7'd1);
    push_pair(OP_READ_ALT,  16'd0,     16'd0,     1'b0, 1'b1, 4'd0,  7'd1);
    push_pair(OP_READ,      16'd0,     16'd0,     1'b0, 1'b0, 4'd15, 7'd65);
    push_pair(OP_READ,      16'd0,     16'd0,     1'b0, 1'b0, 4'd15, 7'd127);
    push_pair(OP_READ,      16'd0,     16'd0,     1'b0, 1'b1, 4'd3,  7'd0);
    wait_for_results();

    // zero widths act as 1, oversized bin counts clamp
    set_binning(16'd1000, 16'd0, 5'd31, 16'd100, 16'd0, 7'd127);
    push_pair(OP_ADD_REAL,  16'd999,   16'd100,   1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd1000,  -16'd99,   1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_MIXED, 16'd1015,  16'd163,   1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_REAL,  16'd1016,  16'd120,   1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_ADD_MIXED, 16'd1005,  -16'd164,  1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_READ,      16'd0,     16'd0,     1'b1, 1'b0, 4'd0,  7'd0);
    push_pair(OP_READ_ALT,  16'd0,     16'd0,     1'b1, 1'b1, 4'd15, 7'd64);
    wait_for_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_binning(16'd0,     16'd100,   5'd16, 16'd0,     16'd10,    7'd64);
        1: set_binning(16'd65535, 16'd65535, 5'd1,  16'd65535, 16'd65535, 7'd1);
        2: set_binning(16'd200,   16'd7,     5'd0,  16'd5,     16'd1,     7'd0);
        3: set_binning(16'd300,   16'd3,     5'd20, 16'd20,    16'd2,     7'd100);
        4: set_binning(16'd0,     16'd1,     5'd16, 16'd0,     16'd1,     7'd64);
        default: set_binning(16'd12345, 16'd250, 5'd9, 16'd40, 16'd37, 7'd33);
      endcase
      repeat (ITEMS_PER_PHASE) begin
        if (random_sent == 650) begin
          send_idle_pct = 52;
          recv_idle_pct <= 24;
        end
        // long result stall while items keep coming
        if (random_sent == 1000) holdoff_len <= 400;
        if (random_sent == 1300) begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
        p = random_pair();
        push_pair(p.op, p.kt, p.q, p.pass, p.rden, p.rkt, p.rq);
        random_sent++;
      end
      wait_for_results();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0)
      $display("** kt_binned_pair_histogrammer: PASSED **");
    else
      $display("** kt_binned_pair_histogrammer: FAILED **");
    $finish;
  end

endmodule

FILE: kt_binned_pair_histogrammer.f
+incdir+hw/rtl
hw/rtl/kbph_pkg.sv
hw/rtl/kbph_ram.sv
hw/rtl/kbph_ctrl.sv
hw/rtl/kbph_dp.sv
hw/rtl/kt_binned_pair_histogrammer.sv
tb/kt_binned_pair_histogrammer_checker.sv
tb/tb_kt_binned_pair_histogrammer.sv
